FILE: design/spta_pkg.sv
// ----------------------------------------------------------------------------
// spta_pkg: shared definitions of the sparse polynomial term accumulator
// Sizes, command and status codes, and the structs passed between the top
// level and the row of term cells.
// ----------------------------------------------------------------------------
package spta_pkg;

    localparam int MAX_TERMS = 64;
    localparam int COEF_BITS = 32;
    localparam int DEG_W     = 16;
    localparam int IDX_W     = 6;
    localparam int CMD_W     = 2;
    localparam int STATUS_W  = 3;
    localparam int CNT_W     = $clog2(MAX_TERMS + 1);
    localparam int POS_W     = $clog2(MAX_TERMS);
    localparam int CMP_W     = IDX_W + CNT_W;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED   = 3'd0,
        ST_MERGED     = 3'd1,
        ST_CANCELLED  = 3'd2,
        ST_DROPPED    = 3'd3,
        ST_IGNORED    = 3'd4,
        ST_READ_OK    = 3'd5,
        ST_READ_EMPTY = 3'd6,
        ST_CLEARED    = 3'd7
    } status_t;

    typedef struct packed {
        logic [DEG_W-1:0]            degree;
        logic signed [COEF_BITS-1:0] coefficient;
    } term_t;

    // Broadcast from the top level to every cell
    typedef struct packed {
        logic             eval;
        logic             is_add;
        logic             is_read;
        logic             commit_merge;
        logic             commit_shift;
        logic             commit_append;
        logic [CNT_W-1:0] count;
        term_t            arg;
        logic [IDX_W-1:0] idx;
        logic [POS_W-1:0] match_pos;
    } cell_ctl_t;

    // Per-cell answer of the evaluation cycle; zero unless the cell is picked
    typedef struct packed {
        logic             match;
        logic             sat;
        logic [POS_W-1:0] pos;
        term_t            term;
    } pick_t;

endpackage

FILE: design/spta_cell.sv
// ----------------------------------------------------------------------------
// spta_cell: one table slot of the term accumulator
// Holds one term, matches it against the broadcast degree, forms the
// saturated sum and takes its neighbour's term when the table closes up.
// ----------------------------------------------------------------------------
module spta_cell (
    input  logic                     clk,
    input  logic                     rst_n,
    input  spta_pkg::cell_ctl_t      ctl,
    input  logic [spta_pkg::POS_W-1:0] pos,
    input  spta_pkg::term_t          nb,
    output spta_pkg::term_t          term,
    output spta_pkg::pick_t          pick
);
    import spta_pkg::*;

    term_t                       term_reg;
    term_t                       term_next;
    pick_t                       pick_reg;
    pick_t                       pick_next;
    logic signed [COEF_BITS:0]   wide_sum;
    logic signed [COEF_BITS-1:0] sat_sum;
    logic                        ovf;
    logic                        occupied;
    logic                        deg_hit;
    logic                        idx_hit;

    always_comb
    begin
        wide_sum = {term_reg.coefficient[COEF_BITS-1], term_reg.coefficient}
                 + {ctl.arg.coefficient[COEF_BITS-1], ctl.arg.coefficient};
        ovf = wide_sum[COEF_BITS] != wide_sum[COEF_BITS-1];
        if (ovf)
        begin
            sat_sum = wide_sum[COEF_BITS] ? {1'b1, {(COEF_BITS-1){1'b0}}}
                                          : {1'b0, {(COEF_BITS-1){1'b1}}};
        end
        else
        begin
            sat_sum = wide_sum[COEF_BITS-1:0];
        end
    end

    assign occupied = CNT_W'(pos) < ctl.count;
    assign deg_hit  = occupied && ctl.is_add && (term_reg.degree == ctl.arg.degree);
    assign idx_hit  = ctl.is_read && (CMP_W'(pos) == CMP_W'(ctl.idx));

    always_comb
    begin
        pick_next = pick_reg;
        if (ctl.eval)
        begin
            pick_next = '0;
            if (deg_hit)
            begin
                pick_next.match            = 1'b1;
                pick_next.sat              = ovf;
                pick_next.pos              = pos;
                pick_next.term.degree      = term_reg.degree;
                pick_next.term.coefficient = sat_sum;
            end
            else if (idx_hit)
            begin
                pick_next.term = term_reg;
            end
        end
    end

    // close up behind a cancelled term, else merge, else take the new term
    always_comb
    begin
        term_next = term_reg;
        if (ctl.commit_shift && (pos >= ctl.match_pos))
        begin
            term_next = nb;
        end
        else if (ctl.commit_merge && pick_reg.match)
        begin
            term_next.coefficient = pick_reg.term.coefficient;
        end
        else if (ctl.commit_append && (CNT_W'(pos) == ctl.count))
        begin
            term_next = ctl.arg;
        end
    end

    always_ff @(posedge clk)
    begin
        term_reg <= term_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pick_reg <= '0;
        end
        else
        begin
            pick_reg <= pick_next;
        end
    end

    assign term = term_reg;
    assign pick = pick_reg;

endmodule

FILE: design/sparse_polynomial_term_accumulator.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_term_accumulator: ordered sparse polynomial term table
// Each accepted beat passes an evaluate state and a commit state, a match-then-commit
// pass over the cell row; its result is registered on the commit. A new beat is taken
// only on the commit of the previous one, so each item sees the table it left.
// Reset: the term count clears to zero and the output is empty; the term
// storage itself is not cleared and is only read below the count.
// ----------------------------------------------------------------------------
module sparse_polynomial_term_accumulator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [spta_pkg::CMD_W-1:0]          command,
    input  logic [spta_pkg::DEG_W-1:0]          degree,
    input  logic signed [spta_pkg::COEF_BITS-1:0] coefficient,
    input  logic [spta_pkg::IDX_W-1:0]          index,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [spta_pkg::STATUS_W-1:0]       status,
    output logic [spta_pkg::DEG_W-1:0]          term_degree,
    output logic signed [spta_pkg::COEF_BITS-1:0] term_coefficient,
    output logic [spta_pkg::CNT_W-1:0]          term_count,
    output logic                                saturated
);
    import spta_pkg::*;

    // One-hot sequencer: wait for a beat, evaluate the row, commit the result
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_EVAL   = 3'b010,
        S_COMMIT = 3'b100
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    cmd_t                        cmd_reg;
    term_t                       arg_reg;
    logic [IDX_W-1:0]            idx_reg;
    logic [CNT_W-1:0]            count_reg;
    logic [CNT_W-1:0]            count_next;

    logic                        out_valid_reg;
    logic                        out_valid_next;
    status_t                     status_reg;
    status_t                     status_next;
    logic [DEG_W-1:0]            deg_reg;
    logic [DEG_W-1:0]            deg_next;
    logic signed [COEF_BITS-1:0] coef_reg;
    logic signed [COEF_BITS-1:0] coef_next;
    logic                        sat_reg;
    logic                        sat_next;

    logic                        in_acc;
    logic                        commit_go;
    logic                        is_add;
    logic                        cancel;
    cell_ctl_t                   ctl;

    term_t                       terms [MAX_TERMS];
    pick_t                       picks [MAX_TERMS];
    logic [MAX_TERMS-1:0]        match_vec;

    logic                        found;
    logic                        pk_sat;
    logic [POS_W-1:0]            pk_pos;
    logic [DEG_W-1:0]            pk_deg;
    logic signed [COEF_BITS-1:0] pk_coef;

    // ------------------------------------------------------------------
    // Handshake: take a beat when idle, or on the edge that commits the
    // previous item, so the next evaluation sees the updated table.
    // ------------------------------------------------------------------
    assign commit_go = (state_reg == S_COMMIT) && (!out_valid_reg || !out_stall);
    assign in_stall  = !((state_reg == S_IDLE) || commit_go);
    assign in_acc    = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (commit_go)
                begin
                    state_next = in_acc ? S_EVAL : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Cell row. Each cell passes its term to the cell one position lower,
    // which takes it when a cancelled term sits at or below its position.
    // ------------------------------------------------------------------
    for (genvar gi = 0; gi < MAX_TERMS; gi++)
    begin : g_cell
        term_t nb;
        if (gi == MAX_TERMS - 1)
        begin : g_last
            assign nb = terms[gi];
        end
        else
        begin : g_mid
            assign nb = terms[gi+1];
        end

        spta_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl),
            .pos   (POS_W'(gi)),
            .nb    (nb),
            .term  (terms[gi]),
            .pick  (picks[gi])
        );

        assign match_vec[gi] = picks[gi].match;
    end

    // Gather the picked cell; at most one cell answers, so an OR suffices
    always_comb
    begin
        found   = 1'b0;
        pk_sat  = 1'b0;
        pk_pos  = '0;
        pk_deg  = '0;
        pk_coef = '0;
        for (int i = 0; i < MAX_TERMS; i++)
        begin
            found   = found   | picks[i].match;
            pk_sat  = pk_sat  | picks[i].sat;
            pk_pos  = pk_pos  | picks[i].pos;
            pk_deg  = pk_deg  | picks[i].term.degree;
            pk_coef = pk_coef | picks[i].term.coefficient;
        end
    end

    // An add with a zero coefficient is dropped before it reaches the row
    assign is_add = (cmd_reg == CMD_ADD) && (arg_reg.coefficient != '0);
    assign cancel = found && (pk_coef == '0);

    always_comb
    begin
        ctl               = '0;
        ctl.eval          = state_reg == S_EVAL;
        ctl.is_add        = is_add;
        ctl.is_read       = cmd_reg == CMD_READ;
        ctl.commit_merge  = commit_go && is_add && found && !cancel;
        ctl.commit_shift  = commit_go && is_add && cancel;
        ctl.commit_append = commit_go && is_add && !found
                            && (count_reg < CNT_W'(MAX_TERMS));
        ctl.count         = count_reg;
        ctl.arg           = arg_reg;
        ctl.idx           = idx_reg;
        ctl.match_pos     = pk_pos;
    end

    // ------------------------------------------------------------------
    // Result and new term count, formed in the commit cycle
    // ------------------------------------------------------------------
    always_comb
    begin
        status_next = ST_IGNORED;
        deg_next    = '0;
        coef_next   = '0;
        sat_next    = 1'b0;
        count_next  = count_reg;
        unique case (cmd_reg)
            CMD_ADD:
            begin
                deg_next = arg_reg.degree;
                if (!is_add)
                begin
                    status_next = ST_IGNORED;
                end
                else if (found)
                begin
                    if (cancel)
                    begin
                        status_next = ST_CANCELLED;
                        count_next  = count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        status_next = ST_MERGED;
                        coef_next   = pk_coef;
                        sat_next    = pk_sat;
                    end
                end
                else if (count_reg == CNT_W'(MAX_TERMS))
                begin
                    status_next = ST_DROPPED;
                    coef_next   = arg_reg.coefficient;
                end
                else
                begin
                    status_next = ST_INSERTED;
                    coef_next   = arg_reg.coefficient;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            CMD_READ:
            begin
                if (CMP_W'(idx_reg) < CMP_W'(count_reg))
                begin
                    status_next = ST_READ_OK;
                    deg_next    = pk_deg;
                    coef_next   = pk_coef;
                end
                else
                begin
                    status_next = ST_READ_EMPTY;
                end
            end
            CMD_CLEAR:
            begin
                status_next = ST_CLEARED;
                count_next  = '0;
            end
            CMD_NOP:
            begin
                status_next = ST_IGNORED;
            end
            default:
            begin
                status_next = ST_IGNORED;
            end
        endcase
    end

    // Output register: load on commit, drop once the beat is taken
    always_comb
    begin
        if (commit_go)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (commit_go)
            begin
                count_reg <= count_next;
            end
        end
    end

    // Payload: hold the accepted beat and the pending result
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg            <= cmd_t'(command);
            arg_reg.degree     <= degree;
            arg_reg.coefficient <= coefficient;
            idx_reg            <= index;
        end
        if (commit_go)
        begin
            status_reg <= status_next;
            deg_reg    <= deg_next;
            coef_reg   <= coef_next;
            sat_reg    <= sat_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign term_degree      = deg_reg;
    assign term_coefficient = coef_reg;
    assign term_count       = count_reg;
    assign saturated        = sat_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    // degrees in the table are unique, so at most one cell may match
    a_single_match: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_COMMIT) |-> $onehot0(match_vec))
        else $error("more than one cell matched the degree");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_TERMS))
        else $error("term count beyond table size");

    a_count_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        !commit_go |=> $stable(count_reg))
        else $error("term count moved outside a commit");

    a_sat_only_merge: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && sat_reg) |-> (status_reg == ST_MERGED))
        else $error("saturation flagged on a non-merge result");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the sparse polynomial term accumulator
// Adds, reads, clears and unused commands are pushed through the valid/stall
// input port with random gaps. Each accepted beat is run through a local
// model of the term table, and every result beat is checked field by field
// against the oldest expected result. The receiver stalls at random, once
// for a long stretch, and the sender twice waits for the pipe to drain.
// ----------------------------------------------------------------------------
module tb;

    import spta_pkg::*;

    localparam int ITEM_TARGET      = 1750;
    localparam int CYCLE_LIMIT      = 1000000;
    localparam int DRAIN_CYCLES     = 20;
    localparam int LONG_HOLD_AT     = 400;
    localparam int LONG_HOLD_CYCLES = 300;

    // Two copies of the term table: one steers stimulus generation, the
    // other predicts results as beats are accepted
    localparam int PLAN_VIEW  = 0;
    localparam int CHECK_VIEW = 1;

    localparam logic signed [COEF_BITS-1:0] COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam logic signed [COEF_BITS-1:0] COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};

    typedef struct packed {
        cmd_t                        cmd;
        logic [DEG_W-1:0]            deg;
        logic signed [COEF_BITS-1:0] coef;
        logic [IDX_W-1:0]            idx;
        logic                        drain_first;
    } term_op_t;

    typedef struct packed {
        status_t                     st;
        logic [DEG_W-1:0]            deg;
        logic signed [COEF_BITS-1:0] coef;
        logic [CNT_W-1:0]            count;
        logic                        sat;
    } term_reply_t;

    logic                          clk   = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [CMD_W-1:0]              command = '0;
    logic [DEG_W-1:0]              degree = '0;
    logic signed [COEF_BITS-1:0]   coefficient = '0;
    logic [IDX_W-1:0]              index = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [STATUS_W-1:0]           status;
    logic [DEG_W-1:0]              term_degree;
    logic signed [COEF_BITS-1:0]   term_coefficient;
    logic [CNT_W-1:0]              term_count;
    logic                          saturated;

    // Term tables of the local model
    logic [DEG_W-1:0]              tbl_deg  [2][MAX_TERMS];
    logic signed [COEF_BITS-1:0]   tbl_coef [2][MAX_TERMS];
    int                            tbl_held [2];

    term_op_t                      pending_terms[$];
    term_reply_t                   expected_results[$];

    // Beat counters move by nonblocking update so each side reads the
    // other's value from before the edge
    int                            accepted_beats = 0;
    int                            result_beats   = 0;
    int                            error_count    = 0;
    int                            cycle_count    = 0;
    int                            stim_items     = 0;
    int                            status_seen[8];
    int                            clamp_seen     = 0;
    bit                            drain_next     = 1'b0;

    int                            send_gap  = 0;
    int                            send_calm = 0;
    int                            recv_hold = 0;
    int                            recv_calm = 0;

    sparse_polynomial_term_accumulator i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .command          (command),
        .degree           (degree),
        .coefficient      (coefficient),
        .index            (index),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .term_degree      (term_degree),
        .term_coefficient (term_coefficient),
        .term_count       (term_count),
        .saturated        (saturated)
    );

    always #10 clk = ~clk;

    // Apply one command to a table copy and return the result it yields
    function automatic term_reply_t apply_term_op(int view, term_op_t op);
        term_reply_t                 res;
        int                          hit;
        int                          held;
        logic signed [COEF_BITS:0]   sum_wide;
        logic signed [COEF_BITS-1:0] sum;
        res.st    = ST_IGNORED;
        res.deg   = '0;
        res.coef  = '0;
        res.sat   = 1'b0;
        held      = tbl_held[view];
        hit       = -1;
        case (op.cmd)
            CMD_ADD:
            begin
                res.deg = op.deg;
                if (op.coef != 0)
                begin
                    for (int i = 0; i < held; i++)
                        if (hit < 0 && tbl_deg[view][i] == op.deg)
                            hit = i;
                    if (hit >= 0)
                    begin
                        sum_wide = $signed({tbl_coef[view][hit][COEF_BITS-1],
                                            tbl_coef[view][hit]})
                                 + $signed({op.coef[COEF_BITS-1], op.coef});
                        if (sum_wide[COEF_BITS] != sum_wide[COEF_BITS-1])
                        begin
                            res.sat = 1'b1;
                            sum     = sum_wide[COEF_BITS] ? COEF_MIN : COEF_MAX;
                        end
                        else
                            sum = sum_wide[COEF_BITS-1:0];
                        if (sum == 0)
                        begin
                            // close up the later terms, keeping their order
                            for (int k = hit; k + 1 < held; k++)
                            begin
                                tbl_deg[view][k]  = tbl_deg[view][k+1];
                                tbl_coef[view][k] = tbl_coef[view][k+1];
                            end
                            held   = held - 1;
                            res.st = ST_CANCELLED;
                        end
                        else
                        begin
                            tbl_coef[view][hit] = sum;
                            res.st   = ST_MERGED;
                            res.coef = sum;
                        end
                    end
                    else if (held >= MAX_TERMS)
                    begin
                        res.st   = ST_DROPPED;
                        res.coef = op.coef;
                    end
                    else
                    begin
                        tbl_deg[view][held]  = op.deg;
                        tbl_coef[view][held] = op.coef;
                        held     = held + 1;
                        res.st   = ST_INSERTED;
                        res.coef = op.coef;
                    end
                end
            end
            CMD_READ:
            begin
                if (op.idx < held)
                begin
                    res.st   = ST_READ_OK;
                    res.deg  = tbl_deg[view][op.idx];
                    res.coef = tbl_coef[view][op.idx];
                end
                else
                    res.st = ST_READ_EMPTY;
            end
            CMD_CLEAR:
            begin
                held   = 0;
                res.st = ST_CLEARED;
            end
            default:
                res.st = ST_IGNORED;
        endcase
        tbl_held[view] = held;
        res.count      = CNT_W'(held);
        return res;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [COEF_BITS-1:0] rand_coef();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return COEF_MAX;
        if (roll == 1)
            return COEF_MIN;
        if (roll < 4)
            return $urandom;
        // small values around zero, a few units of Q16.16
        return $urandom_range(0, 1 << 21) - (1 << 20);
    endfunction

    function automatic bit plan_holds(logic [DEG_W-1:0] deg);
        for (int i = 0; i < tbl_held[PLAN_VIEW]; i++)
            if (tbl_deg[PLAN_VIEW][i] == deg)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [DEG_W-1:0] fresh_degree();
        logic [DEG_W-1:0] deg;
        do
            deg = DEG_W'($urandom);
        while (plan_holds(deg));
        return deg;
    endfunction

    // Read position up to one past the held terms, capped at the last position
    function automatic logic [IDX_W-1:0] plan_index();
        int top;
        top = (tbl_held[PLAN_VIEW] < MAX_TERMS - 1) ? tbl_held[PLAN_VIEW] : MAX_TERMS - 1;
        return IDX_W'($urandom_range(0, top));
    endfunction

    task automatic queue_op(input cmd_t cmd, input logic [DEG_W-1:0] deg,
                            input logic signed [COEF_BITS-1:0] coef,
                            input logic [IDX_W-1:0] idx);
        term_op_t op;
        op.cmd         = cmd;
        op.deg         = deg;
        op.coef        = coef;
        op.idx         = idx;
        op.drain_first = drain_next;
        drain_next     = 1'b0;
        void'(apply_term_op(PLAN_VIEW, op));
        pending_terms.push_back(op);
        if (cmd != CMD_NOP)
            stim_items++;
    endtask

    // Add to a held term: cancel it, push it into the clamp, or plain merge
    task automatic hit_held_term();
        int                          j;
        int                          roll;
        logic signed [COEF_BITS-1:0] held_coef;
        j         = $urandom_range(0, tbl_held[PLAN_VIEW] - 1);
        held_coef = tbl_coef[PLAN_VIEW][j];
        roll      = $urandom_range(0, 2);
        if (roll == 0)
            queue_op(CMD_ADD, tbl_deg[PLAN_VIEW][j], -held_coef, IDX_W'($urandom));
        else if (roll == 1)
            queue_op(CMD_ADD, tbl_deg[PLAN_VIEW][j], held_coef[COEF_BITS-1] ? COEF_MIN : COEF_MAX,
                     IDX_W'($urandom));
        else
            queue_op(CMD_ADD, tbl_deg[PLAN_VIEW][j], rand_coef(), IDX_W'($urandom));
    endtask

    function automatic void compare_field(string name, logic [COEF_BITS-1:0] want,
                                          logic [COEF_BITS-1:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t tb: mismatch on %s, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Reset, stimulus build and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        int               seg;
        int               n;
        int               pool;
        int               top;
        int               roll;
        bit               mid_drain_done;
        logic [DEG_W-1:0] base;

        mid_drain_done = 1'b0;
        for (int s = 0; s < 8; s++)
            status_seen[s] = 0;
        tbl_held[PLAN_VIEW]  = 0;
        tbl_held[CHECK_VIEW] = 0;

        // Directed opening: empty reads, zero add, unused command, both
        // clamps, cancellation with close-up, reads past the end, clear
        queue_op(CMD_READ,  16'h0000, '0,           6'd0);
        queue_op(CMD_ADD,   16'h0000, '0,           6'd0);
        queue_op(CMD_NOP,   16'hFFFF, '1,           6'h3F);
        queue_op(CMD_ADD,   16'hFFFF, COEF_MAX,     6'd0);
        queue_op(CMD_ADD,   16'hFFFF, 32'sd1,       6'd0);
        queue_op(CMD_ADD,   16'h0000, COEF_MIN,     6'd0);
        queue_op(CMD_ADD,   16'h0000, -32'sd1,      6'd0);
        queue_op(CMD_ADD,   16'h0005, 32'h00010000, 6'd0);
        queue_op(CMD_ADD,   16'h0005, 32'h00020000, 6'd0);
        queue_op(CMD_ADD,   16'hFFFF, COEF_MIN + 1, 6'd0);
        queue_op(CMD_READ,  16'h0000, '0,           6'd0);
        queue_op(CMD_READ,  16'h0000, '0,           6'd1);
        queue_op(CMD_READ,  16'h0000, '0,           6'd2);
        queue_op(CMD_READ,  16'hFFFF, '1,           6'h3F);
        queue_op(CMD_ADD,   16'h0000, COEF_MAX,     6'd0);
        queue_op(CMD_ADD,   16'h0000, 32'sd1,       6'd0);
        queue_op(CMD_READ,  16'h0000, '0,           6'd0);
        queue_op(CMD_CLEAR, 16'h0000, '0,           6'd0);
        queue_op(CMD_READ,  16'h0000, '0,           6'd0);
        queue_op(CMD_ADD,   16'hAAAA, 32'h55555555, 6'h2A);
        queue_op(CMD_CLEAR, 16'h5555, 32'hAAAAAAAA, 6'h15);

        // Hold the first random beat until the directed ones are all back
        drain_next = 1'b1;

        while (stim_items < ITEM_TARGET)
        begin
            if (!mid_drain_done && stim_items >= ITEM_TARGET / 2)
            begin
                drain_next     = 1'b1;
                mid_drain_done = 1'b1;
            end
            seg = $urandom_range(0, 99);
            if (seg < 45)
            begin
                // accumulate over a small pool of degrees
                pool = $urandom_range(2, 90);
                base = DEG_W'($urandom);
                n    = $urandom_range(10, 60);
                repeat (n)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 60)
                        queue_op(CMD_ADD, base + DEG_W'($urandom_range(0, pool - 1)),
                                 rand_coef(), IDX_W'($urandom));
                    else if (roll < 82 && tbl_held[PLAN_VIEW] > 0)
                        hit_held_term();
                    else if (roll < 94)
                        queue_op(CMD_READ, DEG_W'($urandom), $urandom, plan_index());
                    else
                        queue_op(CMD_ADD, base + DEG_W'($urandom_range(0, pool - 1)), '0,
                                 IDX_W'($urandom));
                end
            end
            else if (seg < 60)
            begin
                // fill the table, overflow it, then work on the full table
                while (tbl_held[PLAN_VIEW] < MAX_TERMS)
                    queue_op(CMD_ADD, fresh_degree(), rand_coef(), IDX_W'($urandom));
                repeat ($urandom_range(2, 5))
                    queue_op(CMD_ADD, fresh_degree(), rand_coef(), IDX_W'($urandom));
                repeat ($urandom_range(3, 8))
                    hit_held_term();
                for (int k = MAX_TERMS - 4; k < MAX_TERMS; k++)
                    queue_op(CMD_READ, DEG_W'($urandom), $urandom, IDX_W'(k));
                if ($urandom_range(0, 1) == 0)
                    queue_op(CMD_CLEAR, DEG_W'($urandom), $urandom, IDX_W'($urandom));
            end
            else if (seg < 72)
            begin
                // sweep every held position and one past, capped at the last position
                top = (tbl_held[PLAN_VIEW] < MAX_TERMS - 1) ? tbl_held[PLAN_VIEW]
                                                             : MAX_TERMS - 1;
                for (int k = 0; k <= top; k++)
                    queue_op(CMD_READ, DEG_W'($urandom), $urandom, IDX_W'(k));
            end
            else if (seg < 78)
                queue_op(CMD_CLEAR, DEG_W'($urandom), $urandom, IDX_W'($urandom));
            else
            begin
                // noise: any command, any fields
                repeat ($urandom_range(3, 15))
                    queue_op(cmd_t'($urandom_range(0, 3)), DEG_W'($urandom), $urandom,
                             IDX_W'($urandom));
            end
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_terms.size() != 0 || accepted_beats != result_beats)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_results.size() != 0)
        begin
            error_count++;
            $display("%0t tb: %0d expected results never arrived", $time,
                     expected_results.size());
        end

        $display("tb: %0d beats checked; inserted %0d, merged %0d (%0d clamped), cancelled %0d",
                 result_beats, status_seen[ST_INSERTED], status_seen[ST_MERGED], clamp_seen,
                 status_seen[ST_CANCELLED]);
        $display("tb: dropped on full %0d, ignored %0d, reads %0d hit %0d past end, clears %0d",
                 status_seen[ST_DROPPED], status_seen[ST_IGNORED], status_seen[ST_READ_OK],
                 status_seen[ST_READ_EMPTY], status_seen[ST_CLEARED]);
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Input driver: offer the head of the pending queue, hold it until the
    // beat is taken, then idle for a random gap. An item marked to drain
    // first waits until every earlier result has come back.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_terms
        term_op_t    front;
        term_reply_t want;
        bit          offer;
        int          issued;
        if (rst_n)
        begin
            offer  = in_valid;
            issued = accepted_beats;
            if (in_valid && !in_stall)
            begin
                // predict on acceptance so the table follows beat order
                front = pending_terms.pop_front();
                want  = apply_term_op(CHECK_VIEW, front);
                expected_results.push_back(want);
                issued++;
                accepted_beats <= issued;
                offer = 1'b0;
                if (send_calm > 0)
                begin
                    send_calm--;
                    send_gap = 0;
                end
                else
                begin
                    send_gap = pick_gap();
                    if ($urandom_range(0, 199) == 0)
                        send_calm = $urandom_range(40, 120);
                end
            end
            if (!offer)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_terms.size() != 0 &&
                         (!pending_terms[0].drain_first || issued == result_beats))
                begin
                    offer = 1'b1;
                    command     <= pending_terms[0].cmd;
                    degree      <= pending_terms[0].deg;
                    coefficient <= pending_terms[0].coef;
                    index       <= pending_terms[0].idx;
                end
            end
            in_valid <= offer;
        end
    end

    // ------------------------------------------------------------------------
    // Output monitor: check each result beat against the oldest expectation,
    // then stall for a random gap. One long hold lets the block back up
    // into its input while the driver keeps offering.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_results
        term_reply_t want;
        if (rst_n)
        begin
            if (recv_hold > 0)
                recv_hold--;
            if (out_valid && !out_stall)
            begin
                result_beats <= result_beats + 1;
                status_seen[status]++;
                if (saturated === 1'b1)
                    clamp_seen++;
                if (result_beats >= accepted_beats)
                begin
                    error_count++;
                    $display("%0t tb: result with nothing expected, got status %0d deg %0h coef %0h",
                             $time, status, term_degree, term_coefficient);
                end
                else
                begin
                    want = expected_results.pop_front();
                    compare_field("status", want.st, status);
                    compare_field("term_degree", want.deg, term_degree);
                    compare_field("term_coefficient", want.coef, term_coefficient);
                    compare_field("term_count", want.count, term_count);
                    compare_field("saturated", want.sat, saturated);
                end
                if (result_beats + 1 == LONG_HOLD_AT)
                    recv_hold = LONG_HOLD_CYCLES;
                else if (recv_calm > 0)
                begin
                    recv_calm--;
                    recv_hold = 0;
                end
                else
                begin
                    recv_hold = pick_gap();
                    if ($urandom_range(0, 199) == 0)
                        recv_calm = $urandom_range(40, 120);
                end
            end
            out_stall <= (recv_hold > 0);
        end
    end

    // Watchdog: drop out if the run hangs
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t tb: timeout with %0d results outstanding", $time,
                     expected_results.size());
            $display("tb: done, errors");
            $finish;
        end
    end

endmodule
